### rtl/gradient_noise_layer_accumulator_defines.svh
// ----------------------------------------------------------------------------
// gradient_noise_layer_accumulator_defines
// assertion macros shared by the noise accumulator rtl
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_LAYER_ACCUMULATOR_DEFINES_SVH
`define GRADIENT_NOISE_LAYER_ACCUMULATOR_DEFINES_SVH

// check that is switched off while reset is applied
`define GNLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that also holds across reset
`define GNLA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/gnla_pkg.sv
// ----------------------------------------------------------------------------
// gnla_pkg
// types, widths, codes and the fade table of the noise accumulator
// ----------------------------------------------------------------------------
package gnla_pkg;

  // image and grid geometry
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_CELLS   = 16;
  localparam int NODES_SIDE  = MAX_CELLS + 1;
  localparam int NODE_CNT    = NODES_SIDE * NODES_SIDE;
  localparam int NODE_AW     = $clog2(NODE_CNT);
  localparam int VALUE_DEPTH = MAX_WIDTH * MAX_WIDTH;
  localparam int VALUE_AW    = $clog2(VALUE_DEPTH);

  // field widths
  localparam int ACT_W    = 2;
  localparam int NODE_W   = 5;
  localparam int PIX_W    = 9;
  localparam int GRAD_W   = 16;
  localparam int WIDTH_W  = 10;
  localparam int CELLS_W  = 5;
  localparam int WEIGHT_W = 16;
  localparam int VALUE_W  = 17;
  localparam int GREY_W   = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IW   = 2;

  // grid position divider
  localparam int FRAC_W     = 16;
  localparam int TX_W       = PIX_W + 1 + CELLS_W;
  localparam int REM_W      = WIDTH_W + 1;
  localparam int QUO_W      = TX_W - REM_W + FRAC_W;
  localparam int CELL_W     = QUO_W - FRAC_W;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = QUO_W / DIV_BITS;
  localparam int DIV_LAT    = DIV_STAGES + 1;

  // datapath widths
  localparam int OFF_W  = FRAC_W + 1;
  localparam int PROD_W = OFF_W + GRAD_W;
  localparam int DOT_W  = PROD_W + 1;
  localparam int DIFF_W = DOT_W + 1;
  localparam int LP_W   = DIFF_W + VALUE_W + 1;
  localparam int N_W    = DOT_W - 14;
  localparam int NUM_W  = 32;
  localparam int NP_W   = 31;
  localparam int RP_W   = 53;
  localparam int Q0_W   = 21;
  localparam int TOT_W  = 22;
  localparam int WP_W   = TOT_W + WEIGHT_W;
  localparam int ADD_W  = WP_W - 14;
  localparam int SUM_W  = ADD_W + 1;

  // output mapping (1000 n + 707 * 2^16) / 1414, done as a biased reciprocal
  localparam int MAP_MUL   = 1000;
  localparam int MAP_DIV   = 1414;
  localparam int BIAS_K    = 524288;
  localparam int MAP_OFS   = 707 * 65536 + BIAS_K * MAP_DIV;
  localparam longint RECIP = 3037459;
  localparam int RECIP_SH  = 32;
  localparam int ONE_Q16   = 65536;

  // result queue
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = FIFO_AW + 1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_GRAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACCUM = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd3;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_GRID_CELLS   = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_LAYER_WEIGHT = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [NODE_W-1:0]        node_x;
    logic [NODE_W-1:0]        node_y;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [PIX_W-1:0]         pixel_x;
    logic [PIX_W-1:0]         pixel_y;
  } gnla_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [GREY_W-1:0]  grey;
  } gnla_out_t;

  // cosine fade samples at k/16, Q1.16
  localparam logic [VALUE_W-1:0] FADE_TAB [17] = '{
    17'd0, 17'd630, 17'd2494, 17'd5522, 17'd9598, 17'd14563, 17'd20228,
    17'd26375, 17'd32768, 17'd39161, 17'd45308, 17'd50973, 17'd55938,
    17'd60014, 17'd63042, 17'd64906, 17'd65536
  };

  // fade with linear interpolation between table samples
  function automatic logic [VALUE_W-1:0] fade_q16(logic [FRAC_W-1:0] f);
    logic [4:0]         idx;
    logic [11:0]        r;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [12:0]        step;
    logic [24:0]        prod;
    idx  = {1'b0, f[15:12]};
    r    = f[11:0];
    lo   = FADE_TAB[idx];
    hi   = FADE_TAB[idx + 5'd1];
    step = 13'(hi - lo);
    prod = 25'(step) * 25'(r);
    return lo + VALUE_W'(prod >> 12);
  endfunction

endpackage

### rtl/gnla_ram.sv
// ----------------------------------------------------------------------------
// gnla_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module gnla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old data on a same address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/gnla_div.sv
// ----------------------------------------------------------------------------
// gnla_div
// pipelined divider giving grid cell and fraction of one pixel coordinate
// ----------------------------------------------------------------------------
module gnla_div
  import gnla_pkg::*;
(
  input  logic               clk,
  input  logic [PIX_W-1:0]   pix,
  input  logic [CELLS_W-1:0] cells,
  input  logic [REM_W-1:0]   dvsr,
  output logic [CELL_W-1:0]  cell_idx,
  output logic [FRAC_W-1:0]  frac
);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
  } div_state_t;

  // DIV_BITS restoring steps, one quotient bit each
  function automatic div_state_t div_step(div_state_t s, logic [REM_W-1:0] d);
    logic [REM_W:0] trial;
    div_state_t     r;
    r = s;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {r.rem, r.num[QUO_W-1]};
      r.num = {r.num[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        r.rem = REM_W'(trial - {1'b0, d});
        r.quo = {r.quo[QUO_W-2:0], 1'b1};
      end else begin
        r.rem = trial[REM_W-1:0];
        r.quo = {r.quo[QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [TX_W-1:0] tx;
  div_state_t      st [DIV_STAGES];
  div_state_t      st_in;

  // dividend (2p+1)*c scaled by 2^16, top bits already below the divisor
  always_comb begin
    st_in.rem = tx[TX_W-1:TX_W-REM_W];
    st_in.num = {tx[TX_W-REM_W-1:0], {FRAC_W{1'b0}}};
    st_in.quo = '0;
  end

  always_ff @(posedge clk) begin
    tx    <= TX_W'({pix, 1'b1}) * TX_W'(cells);
    st[0] <= div_step(st_in, dvsr);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st[s] <= div_step(st[s-1], dvsr);
    end
  end

  assign cell_idx = st[DIV_STAGES-1].quo[QUO_W-1:FRAC_W];
  assign frac     = st[DIV_STAGES-1].quo[FRAC_W-1:0];

endmodule

### rtl/gnla_fifo.sv
// ----------------------------------------------------------------------------
// gnla_fifo
// result queue between the pipeline and the output channel
// ----------------------------------------------------------------------------
module gnla_fifo
  import gnla_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  gnla_out_t push_data,
  input  logic      pop,
  output logic      valid,
  output gnla_out_t data
);

  gnla_out_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [OCC_W-1:0]   count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + OCC_W'(push) - OCC_W'(pop);
    end
  end

  assign valid = (count != '0);
  assign data  = mem[rd_ptr];

endmodule

### rtl/gradient_noise_layer_accumulator.sv
// ----------------------------------------------------------------------------
// gradient_noise_layer_accumulator
// layered 2d gradient noise summed into a stored value image
// ----------------------------------------------------------------------------
// Items enter on item/item_valid/item_stall and each gives exactly one result
// on result/result_valid/result_stall, in order. An item is taken on a clock
// edge with valid high and stall low. Configuration must be written through
// cfg_write/cfg_index/cfg_data only while no item is in flight; the block
// does not enforce this. Throughput is one item per cycle while item_stall
// is low. From acceptance to result_valid an item passes a pipelined divider
// for the grid position, a read of four gradient ram copies, the dot product,
// blend and mapping stages, and a read-modify-write of the value ram with
// forwarding of the write in flight. Results wait in a 32 entry queue;
// item_stall rises when accepted items not yet taken fill it, so a stalled
// receiver loses nothing. After reset all 262144 value ram entries are swept
// to zero, one entry a cycle, during which item_stall stays high. Gradients
// read as undefined until written.
// ----------------------------------------------------------------------------
`include "gradient_noise_layer_accumulator_defines.svh"

module gradient_noise_layer_accumulator
  import gnla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  gnla_in_t            item,
  output logic                result_valid,
  input  logic                result_stall,
  output gnla_out_t           result,
  input  logic                cfg_write,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  localparam int NSTG     = 10;
  localparam int CORNER_A = 0;
  localparam int CORNER_B = 1;
  localparam int CORNER_C = 2;
  localparam int CORNER_D = 3;

  typedef struct packed {
    logic                valid;
    logic [ACT_W-1:0]    action;
    logic                in_image;
    logic [VALUE_AW-1:0] addr;
  } ctl_t;

  // configuration registers
  logic [WIDTH_W-1:0]         image_width;
  logic [CELLS_W-1:0]         grid_cells;
  logic signed [WEIGHT_W-1:0] layer_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(512);
      grid_cells   <= CELLS_W'(1);
      layer_weight <= WEIGHT_W'(16384);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_W-1:0];
        CFG_GRID_CELLS:   grid_cells   <= cfg_data[CELLS_W-1:0];
        CFG_LAYER_WEIGHT: layer_weight <= $signed(cfg_data[WEIGHT_W-1:0]);
        default: ;
      endcase
    end
  end

  // saturated geometry
  logic [WIDTH_W-1:0] w_eff;
  logic [CELLS_W-1:0] c_eff;
  logic [REM_W-1:0]   dvsr;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (grid_cells == '0) begin
      c_eff = CELLS_W'(1);
    end else if (grid_cells > CELLS_W'(MAX_CELLS)) begin
      c_eff = CELLS_W'(MAX_CELLS);
    end else begin
      c_eff = grid_cells;
    end
    dvsr = {w_eff, 1'b0};
  end

  // acceptance and credit for the result queue
  logic             accept;
  logic             pop;
  logic [OCC_W-1:0] occ;
  logic             clearing;
  logic [VALUE_AW-1:0] clr_cnt;

  assign accept     = item_valid && !item_stall;
  assign pop        = result_valid && !result_stall;
  assign item_stall = clearing || (occ == OCC_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(accept) - OCC_W'(pop);
    end
  end

  // zero sweep of the value ram after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == VALUE_AW'(VALUE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // item delay line beside the dividers
  logic     dly_valid [DIV_LAT];
  gnla_in_t dly_item  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dly_valid[i] <= 1'b0;
      end
    end else begin
      dly_valid[0] <= accept;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_valid[i] <= dly_valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dly_item[0] <= item;
    for (int i = 1; i < DIV_LAT; i++) begin
      dly_item[i] <= dly_item[i-1];
    end
  end

  logic [CELL_W-1:0] cx;
  logic [CELL_W-1:0] cy;
  logic [FRAC_W-1:0] fx;
  logic [FRAC_W-1:0] fy;

  gnla_div u_div_x (
    .clk      (clk),
    .pix      (item.pixel_x),
    .cells    (c_eff),
    .dvsr     (dvsr),
    .cell_idx (cx),
    .frac     (fx)
  );

  gnla_div u_div_y (
    .clk      (clk),
    .pix      (item.pixel_y),
    .cells    (c_eff),
    .dvsr     (dvsr),
    .cell_idx (cy),
    .frac     (fy)
  );

  // gradient stage: write a node or read the four corners
  gnla_in_t           g_item;
  ctl_t               g_ctl;
  logic               gw_en;
  logic [NODE_AW-1:0] gw_addr;
  logic [2*GRAD_W-1:0] gw_data;
  logic [NODE_AW-1:0] g_node  [4];
  logic [2*GRAD_W-1:0] g_rdata [4];

  always_comb begin
    g_item         = dly_item[DIV_LAT-1];
    g_ctl.valid    = dly_valid[DIV_LAT-1];
    g_ctl.action   = g_item.action;
    g_ctl.in_image = ({1'b0, g_item.pixel_x} < w_eff) && ({1'b0, g_item.pixel_y} < w_eff);
    g_ctl.addr     = VALUE_AW'(g_item.pixel_x) * VALUE_AW'(MAX_WIDTH)
                   + VALUE_AW'(g_item.pixel_y);
    gw_en   = g_ctl.valid && (g_item.action == ACT_GRAD)
           && (g_item.node_x <= NODE_W'(MAX_CELLS)) && (g_item.node_y <= NODE_W'(MAX_CELLS));
    gw_addr = NODE_AW'(g_item.node_x) * NODE_AW'(NODES_SIDE) + NODE_AW'(g_item.node_y);
    gw_data = {g_item.grad_x, g_item.grad_y};
    g_node[CORNER_A] = NODE_AW'(cx) * NODE_AW'(NODES_SIDE) + NODE_AW'(cy);
    g_node[CORNER_B] = g_node[CORNER_A] + NODE_AW'(NODES_SIDE);
    g_node[CORNER_C] = g_node[CORNER_B] + NODE_AW'(1);
    g_node[CORNER_D] = g_node[CORNER_A] + NODE_AW'(1);
  end

  for (genvar k = 0; k < 4; k++) begin : g_corner
    gnla_ram #(
      .WIDTH (2*GRAD_W),
      .DEPTH (NODE_CNT)
    ) u_grad_ram (
      .clk     (clk),
      .wr_en   (gw_en),
      .wr_addr (gw_addr),
      .wr_data (gw_data),
      .rd_addr (g_node[k]),
      .rd_data (g_rdata[k])
    );
  end

  // control shift line through the arithmetic stages
  ctl_t ctl [NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) begin
        ctl[i] <= '0;
      end
    end else begin
      ctl[0] <= g_ctl;
      for (int i = 1; i < NSTG; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  // fractions and fades
  logic [FRAC_W-1:0]  h_fx;
  logic [FRAC_W-1:0]  h_fy;
  logic [VALUE_W-1:0] h_u;
  logic [VALUE_W-1:0] h_t;

  always_ff @(posedge clk) begin
    h_fx <= fx;
    h_fy <= fy;
    h_u  <= fade_q16(fx);
    h_t  <= fade_q16(fy);
  end

  // corner offsets times gradients
  logic signed [OFF_W-1:0]  off_x [4];
  logic signed [OFF_W-1:0]  off_y [4];
  logic signed [GRAD_W-1:0] gr_x  [4];
  logic signed [GRAD_W-1:0] gr_y  [4];
  logic signed [PROD_W-1:0] i_px  [4];
  logic signed [PROD_W-1:0] i_py  [4];
  logic [VALUE_W-1:0]       i_u;
  logic [VALUE_W-1:0]       i_t;

  always_comb begin
    off_x[CORNER_A] = $signed({1'b0, h_fx});
    off_x[CORNER_B] = $signed({1'b1, h_fx});
    off_x[CORNER_C] = $signed({1'b1, h_fx});
    off_x[CORNER_D] = $signed({1'b0, h_fx});
    off_y[CORNER_A] = $signed({1'b0, h_fy});
    off_y[CORNER_B] = $signed({1'b0, h_fy});
    off_y[CORNER_C] = $signed({1'b1, h_fy});
    off_y[CORNER_D] = $signed({1'b1, h_fy});
    for (int k = 0; k < 4; k++) begin
      gr_x[k] = $signed(g_rdata[k][2*GRAD_W-1:GRAD_W]);
      gr_y[k] = $signed(g_rdata[k][GRAD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      i_px[k] <= PROD_W'(off_x[k]) * PROD_W'(gr_x[k]);
      i_py[k] <= PROD_W'(off_y[k]) * PROD_W'(gr_y[k]);
    end
    i_u <= h_u;
    i_t <= h_t;
  end

  // dot products
  logic signed [DOT_W-1:0] j_dot [4];
  logic [VALUE_W-1:0]      j_u;
  logic [VALUE_W-1:0]      j_t;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      j_dot[k] <= DOT_W'(i_px[k]) + DOT_W'(i_py[k]);
    end
    j_u <= i_u;
    j_t <= i_t;
  end

  // first blend along x: products
  logic signed [DIFF_W-1:0]  j_dab;
  logic signed [DIFF_W-1:0]  j_ddc;
  logic signed [VALUE_W:0]   j_us;
  logic signed [LP_W-1:0]    k_pab;
  logic signed [LP_W-1:0]    k_pdc;
  logic signed [DOT_W-1:0]   k_da;
  logic signed [DOT_W-1:0]   k_dd;
  logic [VALUE_W-1:0]        k_t;

  always_comb begin
    j_dab = DIFF_W'(j_dot[CORNER_B]) - DIFF_W'(j_dot[CORNER_A]);
    j_ddc = DIFF_W'(j_dot[CORNER_C]) - DIFF_W'(j_dot[CORNER_D]);
    j_us  = $signed({1'b0, j_u});
  end

  always_ff @(posedge clk) begin
    k_pab <= LP_W'(j_dab) * LP_W'(j_us);
    k_pdc <= LP_W'(j_ddc) * LP_W'(j_us);
    k_da  <= j_dot[CORNER_A];
    k_dd  <= j_dot[CORNER_D];
    k_t   <= j_t;
  end

  // first blend along x: sums
  logic signed [DOT_W-1:0] l_ab;
  logic signed [DOT_W-1:0] l_dc;
  logic [VALUE_W-1:0]      l_t;

  always_ff @(posedge clk) begin
    l_ab <= DOT_W'(LP_W'(k_da) + (k_pab >>> FRAC_W));
    l_dc <= DOT_W'(LP_W'(k_dd) + (k_pdc >>> FRAC_W));
    l_t  <= k_t;
  end

  // blend along y: product
  logic signed [DIFF_W-1:0] l_diff;
  logic signed [VALUE_W:0]  l_ts;
  logic signed [LP_W-1:0]   m_p;
  logic signed [DOT_W-1:0]  m_ab;

  always_comb begin
    l_diff = DIFF_W'(l_dc) - DIFF_W'(l_ab);
    l_ts   = $signed({1'b0, l_t});
  end

  always_ff @(posedge clk) begin
    m_p  <= LP_W'(l_diff) * LP_W'(l_ts);
    m_ab <= l_ab;
  end

  // noise in Q16 and biased numerator of the output mapping
  logic signed [DOT_W-1:0] m_x;
  logic signed [N_W-1:0]   m_n;
  logic signed [NUM_W-1:0] m_num;
  logic [NP_W-1:0]         n_np;

  always_comb begin
    m_x   = DOT_W'(LP_W'(m_ab) + (m_p >>> FRAC_W));
    m_n   = N_W'(m_x >>> 14);
    m_num = NUM_W'(m_n) * NUM_W'(MAP_MUL) + NUM_W'(MAP_OFS);
  end

  always_ff @(posedge clk) begin
    n_np <= m_num[NP_W-1:0];
  end

  // reciprocal estimate of the quotient
  logic [RP_W-1:0] n_rp;
  logic [Q0_W-1:0] o_q0;
  logic [NP_W-1:0] o_np;

  assign n_rp = RP_W'(n_np) * RP_W'(RECIP);

  always_ff @(posedge clk) begin
    o_q0 <= n_rp[RECIP_SH+Q0_W-1:RECIP_SH];
    o_np <= n_np;
  end

  // one step correction and bias removal
  logic [NUM_W-1:0]        o_rem;
  logic [Q0_W-1:0]         o_q;
  logic signed [TOT_W-1:0] p_total;

  always_comb begin
    o_rem = NUM_W'(o_np) - NUM_W'(o_q0) * NUM_W'(MAP_DIV);
    o_q   = o_q0 + Q0_W'(o_rem >= NUM_W'(MAP_DIV));
  end

  always_ff @(posedge clk) begin
    p_total <= $signed({1'b0, o_q}) - TOT_W'(BIAS_K);
  end

  // layer weight and value ram read with forwarding
  logic signed [WP_W-1:0] q_wp;
  logic                   byp_hit;
  logic [VALUE_W-1:0]     byp_data;
  logic                   vram_we;
  logic [VALUE_AW-1:0]    vram_wa;
  logic [VALUE_W-1:0]     vram_wd;
  logic [VALUE_W-1:0]     vram_rd;

  always_ff @(posedge clk) begin
    q_wp     <= WP_W'(p_total) * WP_W'(layer_weight);
    byp_hit  <= vram_we && (vram_wa == ctl[NSTG-2].addr);
    byp_data <= vram_wd;
  end

  gnla_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VALUE_DEPTH)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (vram_we),
    .wr_addr (vram_wa),
    .wr_data (vram_wd),
    .rd_addr (ctl[NSTG-2].addr),
    .rd_data (vram_rd)
  );

  // accumulate and clamp, or read or clear, and write back
  ctl_t                    q_ctl;
  logic [VALUE_W-1:0]      q_old;
  logic signed [ADD_W-1:0] q_add;
  logic signed [SUM_W-1:0] q_sum;
  logic [VALUE_W-1:0]      q_clamp;
  logic [VALUE_W-1:0]      res_value;
  logic                    res_write;
  logic [24:0]             grey_prod;
  gnla_out_t               res;

  always_comb begin
    q_ctl = ctl[NSTG-1];
    q_old = byp_hit ? byp_data : vram_rd;
    q_add = ADD_W'(q_wp >>> 14);
    q_sum = SUM_W'(q_add) + SUM_W'($signed({1'b0, q_old}));
    if (q_sum < 0) begin
      q_clamp = '0;
    end else if (q_sum > SUM_W'(ONE_Q16)) begin
      q_clamp = VALUE_W'(ONE_Q16);
    end else begin
      q_clamp = q_sum[VALUE_W-1:0];
    end
    res_value = '0;
    res_write = 1'b0;
    unique case (q_ctl.action)
      ACT_GRAD: ;
      ACT_ACCUM: begin
        res_value = q_ctl.in_image ? q_clamp : '0;
        res_write = q_ctl.in_image;
      end
      ACT_READ:  res_value = q_ctl.in_image ? q_old : '0;
      ACT_CLEAR: res_write = q_ctl.in_image;
      default: ;
    endcase
    grey_prod = 25'(res_value) * 25'(255);
    res.value = res_value;
    res.grey  = grey_prod[23:16];
    if (clearing) begin
      vram_we = 1'b1;
      vram_wa = clr_cnt;
      vram_wd = '0;
    end else begin
      vram_we = q_ctl.valid && res_write;
      vram_wa = q_ctl.addr;
      vram_wd = res_value;
    end
  end

  gnla_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_ctl.valid),
    .push_data (res),
    .pop       (pop),
    .valid     (result_valid),
    .data      (result)
  );

  // checks
  `GNLA_ASSERT(a_occ_bound, occ <= OCC_W'(FIFO_DEPTH), "result credit overrun")
  `GNLA_ASSERT(a_sweep_idle, clearing |-> !q_ctl.valid, "item in flight during ram sweep")
  `GNLA_ASSERT(a_inflight_counted, q_ctl.valid |-> occ != '0, "item in flight not counted")
  `GNLA_ASSERT(a_value_range, result_valid |-> result.value <= VALUE_W'(ONE_Q16), "value overflow")
  `GNLA_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result after reset")

endmodule
